/* sv/mtcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcc_pkg
// Types, codes and helper functions shared by the meter telegram CRC checker.
// ----------------------------------------------------------------------------
package mtcc_pkg;

   localparam logic [7:0]  CH_START      = 8'h2F;   // '/'
   localparam logic [7:0]  CH_END        = 8'h21;   // '!'
   localparam logic [15:0] CRC_POLY_REFL = 16'hA001; // 0x8005 bit-reversed
   localparam logic [15:0] CRC_INIT      = 16'h0000;

   localparam logic [1:0] ST_MATCH    = 2'd0;
   localparam logic [1:0] ST_MISMATCH = 2'd1;
   localparam logic [1:0] ST_BAD_HEX  = 2'd2;

   typedef struct packed {
      logic        valid;
      logic [1:0]  status;
      logic [15:0] crc_computed;
      logic [15:0] crc_received;
   } result_type;

   // Reflected CRC-16 fold of one byte, LSB first.
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

   // Bit 4 set: not a hex digit (nibble reads as 0).
   function automatic logic [4:0] hex_value(input logic [7:0] ch);
      logic [4:0] v;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         v = {1'b0, ch[3:0]};
      end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
         v = {1'b0, ch[3:0] + 4'd9};
      end else begin
         v = 5'h10;
      end
      return v;
   endfunction

endpackage

/* sv/mtcc_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcc_parser
// Telegram phase tracking, running CRC and CRC digit capture; one byte per
// enabled cycle, result presented combinationally.
// ----------------------------------------------------------------------------
module mtcc_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           rx_byte,
   output mtcc_pkg::result_type result
);

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_BODY   = 2'd1,
      PH_DIGITS = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] digits_ff, digits_in;
   logic [1:0]  count_ff, count_in;
   logic        bad_ff, bad_in;
   logic [4:0]  hex;
   logic [15:0] fold_run;
   logic [15:0] fold_new;

   assign hex      = mtcc_pkg::hex_value(rx_byte);
   assign fold_run = mtcc_pkg::crc_fold(crc_ff, rx_byte);
   assign fold_new = mtcc_pkg::crc_fold(mtcc_pkg::CRC_INIT, rx_byte);

   always_comb begin
      phase_in  = phase_ff;
      crc_in    = crc_ff;
      digits_in = digits_ff;
      count_in  = count_ff;
      bad_in    = bad_ff;
      result.valid        = 1'b0;
      result.status       = mtcc_pkg::ST_MATCH;
      result.crc_computed = crc_ff;
      result.crc_received = {digits_ff[11:0], hex[3:0] & {4{~hex[4]}}};
      unique case (phase_ff)
         PH_DIGITS: begin
            digits_in = result.crc_received;
            bad_in    = bad_ff | hex[4];
            count_in  = count_ff + 2'd1;
            if (count_ff == 2'd3) begin
               result.valid = 1'b1;
               phase_in     = PH_IDLE;
               if (bad_in) begin
                  result.status = mtcc_pkg::ST_BAD_HEX;
               end else if (result.crc_received == crc_ff) begin
                  result.status = mtcc_pkg::ST_MATCH;
               end else begin
                  result.status = mtcc_pkg::ST_MISMATCH;
               end
            end
         end
         PH_BODY: begin
            if (rx_byte == mtcc_pkg::CH_START) begin
               crc_in = fold_new;
            end else begin
               crc_in = fold_run;
               if (rx_byte == mtcc_pkg::CH_END) begin
                  phase_in  = PH_DIGITS;
                  digits_in = 16'h0000;
                  count_in  = 2'd0;
                  bad_in    = 1'b0;
               end
            end
         end
         default: begin
            if (rx_byte == mtcc_pkg::CH_START) begin
               phase_in = PH_BODY;
               crc_in   = fold_new;
            end
         end
      endcase
      result.valid = result.valid & step_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         crc_ff    <= 16'h0000;
         digits_ff <= 16'h0000;
         count_ff  <= 2'd0;
         bad_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         crc_ff    <= crc_in;
         digits_ff <= digits_in;
         count_ff  <= count_in;
         bad_ff    <= bad_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY && step_en && rx_byte == mtcc_pkg::CH_END) |=>
         (phase_ff == PH_DIGITS && count_ff == 2'd0 && !bad_ff))
      else $error("mtcc_parser: digit capture not armed after end mark");

   assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (phase_ff == PH_DIGITS && count_ff == 2'd3))
      else $error("mtcc_parser: result outside fourth digit");

   assert property (@(posedge clock) disable iff (reset)
      (step_en && phase_ff == PH_DIGITS && count_ff == 2'd3) |=> (phase_ff == PH_IDLE))
      else $error("mtcc_parser: telegram not closed after fourth digit");

endmodule

/* sv/meter_telegram_crc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_telegram_crc_checker
// Checks the CRC-16/ARC of serial meter telegrams ('/' .. '!' plus four hex
// digits) and reports computed CRC, received CRC and a status per telegram.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req_    | in        | req_valid / req_stall | req_rx_byte
//  rsp_    | out       | rsp_valid / rsp_stall | rsp_status, rsp_crc_computed,
//          |           |                       | rsp_crc_received
//
//  One beat per cycle sustained while req_stall is low; a byte is folded as
//  it leaves the input register, so a telegram's result reaches the result
//  register after its fourth digit passes the input register, then the parser.
//  Synchronous active-high reset clears the telegram state and the valid bits of both registers.
//  A stalled result holds; a byte held in the input register moves on while
//  the result register is empty or being taken, otherwise req_stall rises.
// ----------------------------------------------------------------------------
module meter_telegram_crc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_crc_computed,
   output logic [15:0] rsp_crc_received
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 advance;
   mtcc_pkg::result_type result;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [15:0]          rsp_comp_ff;
   logic [15:0]          rsp_recv_ff;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   mtcc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_status_ff <= result.status;
         rsp_comp_ff   <= result.crc_computed;
         rsp_recv_ff   <= result.crc_received;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_crc_computed = rsp_comp_ff;
   assign rsp_crc_received = rsp_recv_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == mtcc_pkg::ST_MATCH ||
                        rsp_status_ff == mtcc_pkg::ST_MISMATCH ||
                        rsp_status_ff == mtcc_pkg::ST_BAD_HEX))
      else $error("checker: undefined status code");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == mtcc_pkg::ST_MATCH) |-> (rsp_comp_ff == rsp_recv_ff))
      else $error("checker: match reported on differing CRCs");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == mtcc_pkg::ST_MISMATCH) |-> (rsp_comp_ff != rsp_recv_ff))
      else $error("checker: mismatch reported on equal CRCs");

   assert property (@(posedge clock) disable iff (reset)
      (advance && result.valid) |=> rsp_valid_ff)
      else $error("checker: result beat lost");

endmodule
